@@ rtl/core/scld_pkg.sv @@
package scld_pkg;

  localparam int CHANNEL_COUNT = 16;
  localparam int LINE_MAX      = 128;
  localparam int FRAC_DIGITS   = 3;
  localparam int LEN_W         = $clog2(LINE_MAX + 1);

  // command queue between parser and duty pipeline
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // result queue at the output
  localparam int OUT_DEPTH = 8;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);

  localparam logic [17:0] ANGLE_FULL = 18'd180000;
  localparam logic [34:0] ID_LIMIT   = 35'd2147483648;
  localparam logic [31:0] ID_MAX_POS = 32'h7FFF_FFFF;

  // num / (180000 * 8) = (num >> 8) / 5625, the latter by exact reciprocal
  localparam int          DIV_SHIFT   = 8;
  localparam int          RECIP_SHIFT = 42;
  localparam logic [29:0] DUTY_RECIP  =
    30'(((64'd1 << RECIP_SHIFT) + 64'd5624) / 64'd5625);

  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_POINT = 8'd46;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_SEMI  = 8'd59;

  localparam logic CFG_PULSE_LO = 1'b0;
  localparam logic CFG_PULSE_HI = 1'b1;

  localparam logic [18:0] PULSE_LO_RST = 19'd13107;
  localparam logic [18:0] PULSE_HI_RST = 19'd65535;

  typedef enum logic [1:0] {
    ST_APPLIED = 2'd0,
    ST_IGNORED = 2'd1,
    ST_BAD     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_ID    = 2'd0,
    PH_ANGLE = 2'd1,
    PH_REST  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    IDS_LEAD   = 2'd0,
    IDS_SIGN   = 2'd1,
    IDS_DIGITS = 2'd2,
    IDS_STOP   = 2'd3
  } id_stage_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  channel;
    logic [17:0] angle;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [3:0]  channel;
    logic [15:0] duty;
    status_t     status;
  } result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [6:0] frac_weight(input logic [1:0] idx);
    logic [6:0] w;
    case (idx)
      2'd0:    w = 7'd100;
      2'd1:    w = 7'd10;
      default: w = 7'd1;
    endcase
    return w;
  endfunction

endpackage

@@ rtl/core/scld_parser.sv @@
module scld_parser
  import scld_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       char_valid,
  input  logic [7:0] char_code,
  output logic       cmd_push,
  output cmd_t       cmd
);

  logic [LEN_W-1:0] len_r, len_nxt;
  phase_t           phase_r, phase_nxt;
  id_stage_t        id_stage_r, id_stage_nxt;
  logic             id_neg_r, id_neg_nxt;
  logic             id_bad_r, id_bad_nxt;
  logic [31:0]      id_val_r, id_val_nxt;
  logic             a_neg_r, a_neg_nxt;
  logic             a_sign_r, a_sign_nxt;
  logic             a_dig_r, a_dig_nxt;
  logic             a_point_r, a_point_nxt;
  logic             a_stop_r, a_stop_nxt;
  logic             a_present_r, a_present_nxt;
  logic [17:0]      milli_r, milli_nxt;
  logic [1:0]       frac_cnt_r, frac_cnt_nxt;

  logic       is_eol, is_semi, len_full, line_clear, take_char;
  logic [3:0] dig;

  assign is_eol     = (char_code == CH_LF) || (char_code == CH_CR);
  assign is_semi    = (char_code == CH_SEMI);
  assign len_full   = (len_r >= LEN_W'(LINE_MAX));
  assign dig        = char_code[3:0];
  assign line_clear = char_valid && ((is_eol && (len_r != '0)) || (!is_eol && len_full));
  assign take_char  = char_valid && !is_eol && !len_full;
  assign cmd_push   = char_valid && is_eol && (len_r != '0);

  // field phase
  always_comb begin
    phase_nxt = phase_r;
    if (line_clear) begin
      phase_nxt = PH_ID;
    end else if (take_char) begin
      unique case (phase_r)
        PH_ID:    if (is_semi) phase_nxt = PH_ANGLE;
        PH_ANGLE: if (is_semi) phase_nxt = PH_REST;
        PH_REST:  phase_nxt = PH_REST;
        default:  phase_nxt = phase_r;
      endcase
    end
  end

  // field datapath
  always_comb begin
    logic [34:0] id_acc;
    logic [20:0] int_acc;
    logic        leading;
    id_acc  = ({3'b0, id_val_r} << 3) + ({3'b0, id_val_r} << 1) + 35'(dig);
    int_acc = ({3'b0, milli_r} << 3) + ({3'b0, milli_r} << 1) + 21'(dig) * 21'd1000;
    leading = !(a_sign_r || a_dig_r || a_point_r);

    len_nxt       = len_r;
    id_stage_nxt  = id_stage_r;
    id_neg_nxt    = id_neg_r;
    id_bad_nxt    = id_bad_r;
    id_val_nxt    = id_val_r;
    a_neg_nxt     = a_neg_r;
    a_sign_nxt    = a_sign_r;
    a_dig_nxt     = a_dig_r;
    a_point_nxt   = a_point_r;
    a_stop_nxt    = a_stop_r;
    a_present_nxt = a_present_r;
    milli_nxt     = milli_r;
    frac_cnt_nxt  = frac_cnt_r;

    if (line_clear) begin
      len_nxt       = '0;
      id_stage_nxt  = IDS_LEAD;
      id_neg_nxt    = 1'b0;
      id_bad_nxt    = 1'b0;
      id_val_nxt    = '0;
      a_neg_nxt     = 1'b0;
      a_sign_nxt    = 1'b0;
      a_dig_nxt     = 1'b0;
      a_point_nxt   = 1'b0;
      a_stop_nxt    = 1'b0;
      a_present_nxt = 1'b0;
      milli_nxt     = '0;
      frac_cnt_nxt  = '0;
    end else if (take_char) begin
      len_nxt = len_r + LEN_W'(1);
      if (phase_r == PH_ID && !is_semi && id_stage_r != IDS_STOP) begin
        if (is_digit(char_code)) begin
          if (id_acc > ID_LIMIT) begin
            id_val_nxt = 32'(ID_LIMIT + 35'd1);
            id_bad_nxt = 1'b1;
          end else begin
            id_val_nxt = id_acc[31:0];
          end
          id_stage_nxt = IDS_DIGITS;
        end else if (id_stage_r == IDS_LEAD && is_space(char_code)) begin
          id_stage_nxt = id_stage_r;
        end else if (id_stage_r == IDS_LEAD &&
                     (char_code == CH_PLUS || char_code == CH_MINUS)) begin
          id_stage_nxt = IDS_SIGN;
          if (char_code == CH_MINUS) id_neg_nxt = 1'b1;
        end else begin
          if (id_stage_r != IDS_DIGITS) id_bad_nxt = 1'b1;
          id_stage_nxt = IDS_STOP;
        end
      end
      if (phase_r == PH_ANGLE) begin
        a_present_nxt = 1'b1;
        if (!is_semi && !a_stop_r) begin
          if (is_digit(char_code)) begin
            a_dig_nxt = 1'b1;
            if (!a_point_r) begin
              milli_nxt = (int_acc > 21'(ANGLE_FULL)) ? ANGLE_FULL : int_acc[17:0];
            end else if ((32'(frac_cnt_r) < 32'(FRAC_DIGITS)) && (frac_cnt_r != 2'd3)) begin
              milli_nxt    = milli_r + 18'(dig) * 18'(frac_weight(frac_cnt_r));
              frac_cnt_nxt = frac_cnt_r + 2'd1;
            end
          end else if (char_code == CH_POINT && !a_point_r) begin
            a_point_nxt = 1'b1;
          end else if (leading && is_space(char_code)) begin
            a_stop_nxt = a_stop_r;
          end else if (leading && (char_code == CH_PLUS || char_code == CH_MINUS)) begin
            a_sign_nxt = 1'b1;
            if (char_code == CH_MINUS) a_neg_nxt = 1'b1;
          end else begin
            a_stop_nxt = 1'b1;
          end
        end
      end
    end
  end

  // line classification, valid in the cycle of the line end
  always_comb begin
    logic id_ok, out_range;
    id_ok     = !id_bad_r && (id_stage_r == IDS_DIGITS || id_stage_r == IDS_STOP);
    if (id_ok && !id_neg_r && (id_val_r > ID_MAX_POS)) id_ok = 1'b0;
    out_range = (id_neg_r && id_val_r != '0) || (id_val_r > 32'd15) ||
                (id_val_r >= 32'(CHANNEL_COUNT));
    cmd.channel = '0;
    cmd.angle   = '0;
    if (!id_ok) begin
      cmd.status = ST_BAD;
    end else if (!a_present_r) begin
      cmd.status = ST_IGNORED;
    end else if (!a_dig_r) begin
      cmd.status = ST_BAD;
    end else if (out_range) begin
      cmd.status = ST_IGNORED;
    end else begin
      cmd.status  = ST_APPLIED;
      cmd.channel = id_val_r[3:0];
      cmd.angle   = a_neg_r ? '0 : ((milli_r > ANGLE_FULL) ? ANGLE_FULL : milli_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      phase_r     <= PH_ID;
      id_stage_r  <= IDS_LEAD;
      id_neg_r    <= 1'b0;
      id_bad_r    <= 1'b0;
      id_val_r    <= '0;
      a_neg_r     <= 1'b0;
      a_sign_r    <= 1'b0;
      a_dig_r     <= 1'b0;
      a_point_r   <= 1'b0;
      a_stop_r    <= 1'b0;
      a_present_r <= 1'b0;
      milli_r     <= '0;
      frac_cnt_r  <= '0;
    end else begin
      len_r       <= len_nxt;
      phase_r     <= phase_nxt;
      id_stage_r  <= id_stage_nxt;
      id_neg_r    <= id_neg_nxt;
      id_bad_r    <= id_bad_nxt;
      id_val_r    <= id_val_nxt;
      a_neg_r     <= a_neg_nxt;
      a_sign_r    <= a_sign_nxt;
      a_dig_r     <= a_dig_nxt;
      a_point_r   <= a_point_nxt;
      a_stop_r    <= a_stop_nxt;
      a_present_r <= a_present_nxt;
      milli_r     <= milli_nxt;
      frac_cnt_r  <= frac_cnt_nxt;
    end
  end

endmodule

@@ rtl/core/scld_cmd_queue.sv @@
module scld_cmd_queue
  import scld_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head_cmd,
  output q_stat_t stat
);

  cmd_t            mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign stat.full  = (cnt_r == (Q_AW + 1)'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_cmd   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_AW'(1);
    end
    if (do_push && !do_pop) cnt_nxt = cnt_r + (Q_AW + 1)'(1);
    if (!do_push && do_pop) cnt_nxt = cnt_r - (Q_AW + 1)'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ rtl/core/scld_duty_pipe.sv @@
module scld_duty_pipe
  import scld_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  q_stat_t     q_stat,
  input  cmd_t        head_cmd,
  output logic        cmd_pop,
  input  logic [18:0] lo_eighths,
  input  logic [18:0] hi_eighths,
  input  logic        res_pop,
  output logic        res_empty,
  output result_t     res
);

  // stage a: the two products of the linear map
  logic        va_r;
  logic [36:0] a_p0_r, a_p1_r;
  status_t     a_stat_r;
  logic [3:0]  a_chan_r;
  // stage b: sum with the power-of-two part of the divisor removed
  logic        vb_r;
  logic [28:0] b_x_r;
  status_t     b_stat_r;
  logic [3:0]  b_chan_r;
  // stage c: reciprocal product
  logic        vc_r;
  logic [58:0] c_t_r;
  status_t     c_stat_r;
  logic [3:0]  c_chan_r;

  result_t           omem [OUT_DEPTH];
  logic [OUT_AW-1:0] owr_ptr_r, owr_ptr_nxt;
  logic [OUT_AW-1:0] ord_ptr_r, ord_ptr_nxt;
  logic [OUT_AW:0]   ocnt_r, ocnt_nxt;
  logic              opush, opop;
  result_t           ores;

  logic [17:0] angle_comp;
  logic [37:0] b_sum;

  // only issue when the result queue has a slot for everything in flight
  assign cmd_pop = !q_stat.empty &&
                   ((32'(ocnt_r) + 32'(va_r) + 32'(vb_r) + 32'(vc_r)) < 32'(OUT_DEPTH));

  assign angle_comp = ANGLE_FULL - head_cmd.angle;
  assign b_sum      = 38'(a_p0_r) + 38'(a_p1_r);

  always_ff @(posedge clk) begin
    a_p0_r   <= 37'(lo_eighths) * 37'(angle_comp);
    a_p1_r   <= 37'(hi_eighths) * 37'(head_cmd.angle);
    a_stat_r <= head_cmd.status;
    a_chan_r <= head_cmd.channel;
    b_x_r    <= b_sum[DIV_SHIFT +: 29];
    b_stat_r <= a_stat_r;
    b_chan_r <= a_chan_r;
    c_t_r    <= 59'(b_x_r) * 59'(DUTY_RECIP);
    c_stat_r <= b_stat_r;
    c_chan_r <= b_chan_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= cmd_pop;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_comb begin
    ores.status  = c_stat_r;
    ores.channel = c_chan_r;
    ores.duty    = (c_stat_r == ST_APPLIED) ? c_t_r[RECIP_SHIFT +: 16] : '0;
  end

  assign opush     = vc_r;
  assign res_empty = (ocnt_r == '0);
  assign opop      = res_pop && !res_empty;
  assign res       = omem[ord_ptr_r];

  always_comb begin
    owr_ptr_nxt = owr_ptr_r;
    ord_ptr_nxt = ord_ptr_r;
    ocnt_nxt    = ocnt_r;
    if (opush) begin
      owr_ptr_nxt = (owr_ptr_r == OUT_AW'(OUT_DEPTH - 1)) ? '0 : owr_ptr_r + OUT_AW'(1);
    end
    if (opop) begin
      ord_ptr_nxt = (ord_ptr_r == OUT_AW'(OUT_DEPTH - 1)) ? '0 : ord_ptr_r + OUT_AW'(1);
    end
    if (opush && !opop) ocnt_nxt = ocnt_r + (OUT_AW + 1)'(1);
    if (!opush && opop) ocnt_nxt = ocnt_r - (OUT_AW + 1)'(1);
  end

  always_ff @(posedge clk) begin
    if (opush) omem[owr_ptr_r] <= ores;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_ptr_r <= '0;
      ord_ptr_r <= '0;
      ocnt_r    <= '0;
    end else begin
      owr_ptr_r <= owr_ptr_nxt;
      ord_ptr_r <= ord_ptr_nxt;
      ocnt_r    <= ocnt_nxt;
    end
  end

endmodule

@@ rtl/core/servo_command_line_decoder_core.sv @@
// Servo command line decoder. Bytes of lines "id;angle" ended by LF or CR go in one per
// cycle while in_full is low; each non-empty line gives one result (channel, duty,
// status) on the result queue. Status 0 applies the duty, 1 means no angle or an id
// outside the channel range, 2 means a malformed number; for status 1 and 2 channel and
// duty read 0. That byte rate is set by the parser updating its field state in a single
// step per byte. A line end reaches the result queue through the command queue, then a
// three-stage duty pipeline (products, sum, reciprocal divide). in_full rises only while
// four finished lines wait in the command queue, which happens when results are not popped.
// The duty registers are to be written only while no line is in flight.
module servo_command_line_decoder_core
  import scld_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_char_code,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [3:0]  out_channel,
  output logic [15:0] out_duty,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [18:0] cfg_wdata
);

  logic [18:0] lo_eighths_r, hi_eighths_r;
  logic        char_valid, cmd_push, cmd_pop;
  cmd_t        new_cmd, head_cmd;
  q_stat_t     q_stat;
  result_t     res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_eighths_r <= PULSE_LO_RST;
      hi_eighths_r <= PULSE_HI_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PULSE_LO: lo_eighths_r <= cfg_wdata;
        CFG_PULSE_HI: hi_eighths_r <= cfg_wdata;
        default:      lo_eighths_r <= lo_eighths_r;
      endcase
    end
  end

  assign in_full    = q_stat.full;
  assign char_valid = in_push && !in_full;

  scld_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .char_valid(char_valid),
    .char_code (in_char_code),
    .cmd_push  (cmd_push),
    .cmd       (new_cmd)
  );

  scld_cmd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .push_cmd(new_cmd),
    .pop     (cmd_pop),
    .head_cmd(head_cmd),
    .stat    (q_stat)
  );

  scld_duty_pipe u_duty (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head_cmd  (head_cmd),
    .cmd_pop   (cmd_pop),
    .lo_eighths(lo_eighths_r),
    .hi_eighths(hi_eighths_r),
    .res_pop   (out_pop),
    .res_empty (out_empty),
    .res       (res)
  );

  assign out_channel = res.channel;
  assign out_duty    = res.duty;
  assign out_status  = res.status;

endmodule

@@ rtl/core/scld_checker.sv @@
module scld_checker
  import scld_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_push,
  input logic        in_full,
  input logic [7:0]  in_char_code,
  input logic        out_empty,
  input logic        out_pop,
  input logic [3:0]  out_channel,
  input logic [15:0] out_duty,
  input logic [1:0]  out_status
);

  // a not-applied result carries no channel and no duty
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != ST_APPLIED) |-> (out_channel == 4'd0 && out_duty == 16'd0))
    else $error("rejected result with nonzero channel or duty");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_status == ST_APPLIED || out_status == ST_IGNORED ||
                    out_status == ST_BAD))
    else $error("illegal status code");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // the command queue only fills on a line end transfer
  a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_full) |-> $past(in_push && (in_char_code == CH_LF || in_char_code == CH_CR)))
    else $error("full raised without a line end");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_duty) && $stable(out_status)))
    else $error("waiting result changed");

endmodule

bind servo_command_line_decoder_core scld_checker u_scld_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_push     (in_push),
  .in_full     (in_full),
  .in_char_code(in_char_code),
  .out_empty   (out_empty),
  .out_pop     (out_pop),
  .out_channel (out_channel),
  .out_duty    (out_duty),
  .out_status  (out_status)
);

@@ sim/duty_result_checker.sv @@
`timescale 1ns / 1ps

module duty_result_checker
  import scld_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [7:0]  in_char_code,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [3:0]  out_channel,
  input  logic [15:0] out_duty,
  input  logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [18:0] cfg_wdata,
  output int          mismatch_count,
  output int          awaited_count
);

  localparam longint unsigned FULL_SWING = 64'd180000;

  result_t     awaited_results[$];

  // duty endpoints as the block should hold them
  logic [18:0] duty_lo;
  logic [18:0] duty_hi;

  // line parser state
  int unsigned kept_len;
  phase_t      field;
  logic [31:0] id_mag;
  id_stage_t   id_stage;
  logic        id_neg;
  logic        id_bad;
  int unsigned angle_milli;
  int unsigned frac_taken;
  logic        a_neg;
  logic        a_sign;
  logic        a_dig;
  logic        a_point;
  logic        a_stop;
  logic        a_present;

  function automatic logic blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic numeral(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  task automatic clear_line();
    kept_len    = 0;
    field       = PH_ID;
    id_mag      = '0;
    id_stage    = IDS_LEAD;
    id_neg      = 1'b0;
    id_bad      = 1'b0;
    angle_milli = 0;
    frac_taken  = 0;
    a_neg       = 1'b0;
    a_sign      = 1'b0;
    a_dig       = 1'b0;
    a_point     = 1'b0;
    a_stop      = 1'b0;
    a_present   = 1'b0;
  endtask

  task automatic take_id_char(input logic [7:0] c);
    logic [35:0] grown;
    if (id_stage == IDS_STOP) return;
    if (numeral(c)) begin
      grown = 36'(id_mag) * 36'd10 + 36'(c - CH_ZERO);
      // pin just above the signed range so later digits cannot wrap it back
      if (grown > 36'(ID_LIMIT)) begin
        grown  = 36'(ID_LIMIT) + 36'd1;
        id_bad = 1'b1;
      end
      id_mag   = grown[31:0];
      id_stage = IDS_DIGITS;
    end else if (id_stage == IDS_LEAD && blank(c)) begin
    end else if (id_stage == IDS_LEAD && (c == CH_PLUS || c == CH_MINUS)) begin
      id_stage = IDS_SIGN;
      if (c == CH_MINUS) id_neg = 1'b1;
    end else begin
      if (id_stage != IDS_DIGITS) id_bad = 1'b1;
      id_stage = IDS_STOP;
    end
  endtask

  task automatic take_angle_char(input logic [7:0] c);
    logic        leading;
    int unsigned d;
    int unsigned grown;
    leading = !(a_sign || a_dig || a_point);
    if (a_stop) return;
    if (numeral(c)) begin
      d     = 32'(c - CH_ZERO);
      a_dig = 1'b1;
      if (!a_point) begin
        grown       = angle_milli * 10 + d * 1000;
        angle_milli = (grown > 32'(FULL_SWING)) ? 32'(FULL_SWING) : grown;
      end else if (frac_taken < FRAC_DIGITS && frac_taken < 3) begin
        case (frac_taken)
          0:       angle_milli += d * 100;
          1:       angle_milli += d * 10;
          default: angle_milli += d;
        endcase
        frac_taken++;
      end
    end else if (c == CH_POINT && !a_point) begin
      a_point = 1'b1;
    end else if (leading && blank(c)) begin
    end else if (leading && (c == CH_PLUS || c == CH_MINUS)) begin
      a_sign = 1'b1;
      if (c == CH_MINUS) a_neg = 1'b1;
    end else begin
      a_stop = 1'b1;
    end
  endtask

  function automatic result_t line_verdict();
    result_t         r;
    logic            id_ok;
    longint unsigned a;
    longint unsigned num;
    longint unsigned q;
    r     = '0;
    id_ok = !id_bad && (id_stage == IDS_DIGITS || id_stage == IDS_STOP);
    if (id_ok && !id_neg && id_mag > ID_MAX_POS) id_ok = 1'b0;
    if (!id_ok) begin
      r.status = ST_BAD;
    end else if (!a_present) begin
      r.status = ST_IGNORED;
    end else if (!a_dig) begin
      r.status = ST_BAD;
    end else if ((id_neg && id_mag != 0) || id_mag > 15 || id_mag >= CHANNEL_COUNT) begin
      r.status = ST_IGNORED;
    end else begin
      a = a_neg ? 64'd0 : 64'(angle_milli);
      if (a > FULL_SWING) a = FULL_SWING;
      num = 64'(duty_lo) * (FULL_SWING - a) + 64'(duty_hi) * a;
      q   = num / (FULL_SWING * 64'd8);
      if (q > 64'd65535) q = 64'd65535;
      r.channel = id_mag[3:0];
      r.duty    = 16'(q);
      r.status  = ST_APPLIED;
    end
    return r;
  endfunction

  task automatic take_char(input logic [7:0] c);
    if (c == CH_LF || c == CH_CR) begin
      if (kept_len != 0) begin
        awaited_results.push_back(line_verdict());
        clear_line();
      end
    end else if (kept_len >= LINE_MAX) begin
      // overlong line: drop it together with this byte
      clear_line();
    end else begin
      kept_len++;
      case (field)
        PH_ID: begin
          if (c == CH_SEMI) field = PH_ANGLE;
          else take_id_char(c);
        end
        PH_ANGLE: begin
          a_present = 1'b1;
          if (c == CH_SEMI) field = PH_REST;
          else take_angle_char(c);
        end
        default: begin
        end
      endcase
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      duty_lo = PULSE_LO_RST;
      duty_hi = PULSE_HI_RST;
      clear_line();
      awaited_results.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_PULSE_LO) duty_lo = cfg_wdata;
        else duty_hi = cfg_wdata;
      end
      if (out_pop && !out_empty) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with nothing expected: channel %0d duty %0d status %0d",
                 out_channel, out_duty, out_status);
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("channel", want.channel, out_channel);
          check_field("duty", want.duty, out_duty);
          check_field("status", want.status, out_status);
        end
      end
      if (in_push && !in_full) take_char(in_char_code);
    end
    awaited_count = awaited_results.size();
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import scld_pkg::*;

  localparam int          STALL_LIMIT     = 2000;
  localparam int          CHARS_PER_PHASE = 145;
  localparam int          PHASES          = 8;
  localparam logic [18:0] DUTY_CODE_TOP   = 19'd524280;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [7:0]  in_char_code;
  logic        out_empty;
  logic        out_pop;
  logic [3:0]  out_channel;
  logic [15:0] out_duty;
  logic [1:0]  out_status;
  logic        cfg_we;
  logic        cfg_index;
  logic [18:0] cfg_wdata;

  int          mismatch_count;
  int          awaited_count;
  int          quiet_cycles;
  logic [7:0]  char_stream[$];
  bit          feed_calm;
  bit          drain_calm;

  servo_command_line_decoder_core i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_char_code (in_char_code),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_channel  (out_channel),
    .out_duty     (out_duty),
    .out_status   (out_status),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  duty_result_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_char_code   (in_char_code),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_channel    (out_channel),
    .out_duty       (out_duty),
    .out_status     (out_status),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .awaited_count  (awaited_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // occasional stretches with no idling at all
  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) char_stream.push_back(s[i]);
  endtask

  task automatic add_repeat(input logic [7:0] c, input int n);
    repeat (n) char_stream.push_back(c);
  endtask

  task automatic add_random_line();
    int    kind;
    int    mag;
    string marks;
    marks = ";;+-. \t";
    kind  = $urandom_range(0, 99);
    if (kind < 78) begin
      if ($urandom_range(0, 5) == 0) char_stream.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      case ($urandom_range(0, 11))
        0:       add_text("-");
        1:       add_text("+");
        default: begin
        end
      endcase
      mag = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 999) : $urandom_range(0, 15);
      if ($urandom_range(0, 9) == 0) add_text("0");
      add_text($sformatf("%0d", mag));
      if ($urandom_range(0, 15) == 0) add_text(" ");
      if ($urandom_range(0, 15) != 0) begin
        add_text(";");
        if ($urandom_range(0, 7) == 0) add_text(" ");
        case ($urandom_range(0, 9))
          0:       add_text("-");
          1:       add_text("+");
          default: begin
          end
        endcase
        if ($urandom_range(0, 9) != 0) begin
          mag = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99999) : $urandom_range(0, 200);
          add_text($sformatf("%0d", mag));
        end
        if ($urandom_range(0, 1) != 0) begin
          add_text(".");
          repeat ($urandom_range(0, 5)) char_stream.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        end
        if ($urandom_range(0, 7) == 0) begin
          if ($urandom_range(0, 1) != 0) add_text(";x");
          else add_text("a1");
        end
      end
      case ($urandom_range(0, 3))
        0:       add_text("\r");
        1:       add_text("\r\n");
        default: add_text("\n");
      endcase
    end else if (kind < 99) begin
      repeat ($urandom_range(0, 12)) begin
        case ($urandom_range(0, 2))
          0:       char_stream.push_back(8'($urandom_range(0, 255)));
          1:       char_stream.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
          default: char_stream.push_back(marks[$urandom_range(0, marks.len() - 1)]);
        endcase
      end
      add_text("\n");
    end else begin
      repeat ($urandom_range(125, 135)) begin
        char_stream.push_back($urandom_range(0, 9) == 0 ? CH_SEMI : 8'(CH_ZERO + $urandom_range(0, 9)));
      end
      add_text("\n");
    end
  endtask

  task automatic add_directed();
    add_text("0;0\n");
    add_text("15;180\n");
    add_text(" 7;\t+90.5\r");
    add_text("3;-10\r\n");
    add_text("\n");
    add_text("4;999999.999\n");
    add_text("16;90\n");
    add_text("-1;90\n");
    add_text("-0;45.0004\n");
    add_text("2147483647;5\n");
    add_text("2147483648;5\n");
    add_text("-2147483648;5\n");
    add_text("99999999999;5\n");
    add_text(";5\n");
    add_text("+ 2;5\n");
    add_text("5\n");
    add_text("5;\n");
    add_text("3;;\n");
    add_text("4;-.\n");
    add_text("6 x;12.34567.8\n");
    add_text("9;.5;7\n");
    add_text("10;- 3\n");
    add_text("11;1");
    char_stream.push_back(8'h80);
    char_stream.push_back(8'hFF);
    char_stream.push_back(8'h00);
    add_text("\n");
    // exactly full line, then one that overflows and restarts mid-field
    add_text("1;");
    add_repeat("9", LINE_MAX - 2);
    add_text("\n");
    add_repeat("0", LINE_MAX);
    add_text("5;20\n");
  endtask

  task automatic push_char(input logic [7:0] c);
    int gap;
    bit taken;
    gap = draw_gap(feed_calm);
    if (gap > 0) begin
      in_push      <= 1'b0;
      in_char_code <= 8'($urandom_range(0, 255));
      repeat (gap) @(posedge clk);
    end
    in_push      <= 1'b1;
    in_char_code <= c;
    do begin
      @(negedge clk);
      taken = !in_full;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic send_stream();
    while (char_stream.size() != 0) push_char(char_stream.pop_front());
    in_push <= 1'b0;
  endtask

  task automatic wait_results_drained();
    do @(negedge clk); while (awaited_count != 0);
  endtask

  task automatic program_duty(input logic [18:0] lo, input logic [18:0] hi);
    wait_results_drained();
    // let the duty pipeline settle before touching its endpoints
    repeat (10) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PULSE_LO;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= CFG_PULSE_HI;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    logic [18:0] lo;
    logic [18:0] hi;
    in_push      <= 1'b0;
    in_char_code <= 8'd0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_PULSE_LO;
    cfg_wdata    <= '0;
    rst_n        <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    add_directed();
    send_stream();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          lo = '0;
          hi = DUTY_CODE_TOP;
        end
        1: begin
          lo = DUTY_CODE_TOP;
          hi = '0;
        end
        2: begin
          lo = '0;
          hi = '0;
        end
        3: begin
          lo = DUTY_CODE_TOP;
          hi = DUTY_CODE_TOP;
        end
        default: begin
          lo = 19'($urandom_range(0, DUTY_CODE_TOP));
          hi = 19'($urandom_range(0, DUTY_CODE_TOP));
        end
      endcase
      program_duty(lo, hi);
      while (char_stream.size() < CHARS_PER_PHASE) add_random_line();
      send_stream();
    end

    wait_results_drained();
    repeat (20) @(posedge clk);
    if (awaited_count != 0) $error("%0d expected results never arrived", awaited_count);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("servo_command_line_decoder_core regression: pass");
    end else begin
      $display("servo_command_line_decoder_core regression: fail");
    end
    $finish;
  end

  initial begin : result_drain
    int gap;
    bit taken;
    out_pop <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = draw_gap(drain_calm);
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      do begin
        @(negedge clk);
        taken = !out_empty;
        @(posedge clk);
      end while (!taken);
    end
  end

  // no transfer on either side for too long means the block hung
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("servo_command_line_decoder_core regression: fail");
      $finish;
    end
  end

endmodule
